[hw/rtl/square_free_part_defines.svh]
// Assertion macros for the square-free part RTL.
`ifndef SQUARE_FREE_PART_DEFINES_SVH
`define SQUARE_FREE_PART_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define SFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define SFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SFP_ASSERT(lbl, clk, rst_n, prop, msg)

`define SFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/sfp_pkg.sv]
// Package of the square-free part block: widths, datapath operations, control structs.
package sfp_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int VAL_W      = DATA_WIDTH - 1;          // value bits
    localparam int TDATA_W    = ((VAL_W + 7) / 8) * 8;   // stream data bits
    localparam int FW         = VAL_W / 3 + 2;           // trial factor bits
    localparam int CW         = VAL_W + 3;               // square and cube bits
    localparam int GW         = FW + 2;                  // 3f+2 bits
    localparam int SQ_IT      = (VAL_W + 1) / 2;         // root digits
    localparam int SRC_W      = 2 * SQ_IT;
    localparam int RW         = SQ_IT + 3;               // root remainder bits
    localparam int DIV_CW     = $clog2(VAL_W + 1);
    localparam int SQ_CW      = $clog2(SQ_IT + 1);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,     // take a new value, reset keep and trial factor
        OP_SHR2,     // drop a factor of 4
        OP_SHR1,     // drop the last factor of 2, keep 2
        OP_DIV,      // start v / f
        OP_TAKE,     // v <= quotient, flip parity
        OP_MUL_KF,   // keep <= keep * f
        OP_CUBE_A,   // cube += 4 sq
        OP_CUBE_B,   // cube += 2 sq
        OP_CUBE_C,   // cube += 12f+8, advance f, sq, g
        OP_SQRT,     // start integer root of v
        OP_SET_ONE,  // v <= 1
        OP_MUL_KV,   // keep <= keep * v
        OP_EMIT      // load the output register
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic v_zero;
        logic v_low2_zero;
        logic v_low_zero;
        logic cube_le_v;
        logic div_busy;
        logic rem_zero;
        logic odd;
        logic mul_busy;
        logic sqrt_busy;
        logic sqrt_exact;
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/sfp_div.sv]
// Bit-serial restoring divider: value by trial factor, one quotient bit a cycle.
module sfp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sfp_pkg::VAL_W-1:0]     i_dividend,
    input  logic [sfp_pkg::FW-1:0]        i_divisor,
    output logic                          o_busy,
    output logic [sfp_pkg::VAL_W-1:0]     o_quot,
    output logic                          o_rem_zero
);

    logic [sfp_pkg::DIV_CW-1:0] r_cnt;
    logic [sfp_pkg::VAL_W-1:0]  r_q;
    logic [sfp_pkg::FW-1:0]     r_rem;
    logic [sfp_pkg::FW-1:0]     r_d;
    logic [sfp_pkg::FW:0]       trial;
    logic [sfp_pkg::FW:0]       diff;
    logic                       fits;

    assign trial = {r_rem, r_q[sfp_pkg::VAL_W-1]};
    assign fits  = trial >= {1'b0, r_d};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= sfp_pkg::DIV_CW'(sfp_pkg::VAL_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[sfp_pkg::VAL_W-2:0], fits};
            r_rem <= fits ? diff[sfp_pkg::FW-1:0] : trial[sfp_pkg::FW-1:0];
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quot     = r_q;
    assign o_rem_zero = r_rem == '0;

endmodule

[hw/rtl/sfp_dpath.sv]
// Datapath: value, kept factors, trial factor with square and cube, multiplier,
// root unit and output register.
module sfp_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfp_pkg::t_cmd               i_cmd,
    input  logic [sfp_pkg::VAL_W-1:0]   i_in_data,
    output sfp_pkg::t_sts               o_sts,
    output logic                        o_out_valid,
    output logic [sfp_pkg::VAL_W-1:0]   o_out_data,
    input  logic                        i_out_ready
);

    logic [sfp_pkg::VAL_W-1:0] r_v;
    logic [sfp_pkg::VAL_W-1:0] r_keep;
    logic [sfp_pkg::FW-1:0]    r_f;
    logic [sfp_pkg::GW-1:0]    r_g;
    logic [sfp_pkg::CW-1:0]    r_sq;
    logic [sfp_pkg::CW-1:0]    r_cube;
    logic                      r_odd;

    logic                      r_mul_busy;
    logic [sfp_pkg::VAL_W-1:0] r_ma;
    logic [sfp_pkg::VAL_W-1:0] r_mb;
    logic [sfp_pkg::VAL_W-1:0] r_macc;
    logic                      mul_done;

    logic [sfp_pkg::SQ_CW-1:0] r_scnt;
    logic [sfp_pkg::SRC_W-1:0] r_src;
    logic [sfp_pkg::RW-1:0]    r_srem;
    logic [sfp_pkg::SQ_IT-1:0] r_root;
    logic [sfp_pkg::RW-1:0]    rem_sh;
    logic [sfp_pkg::RW-1:0]    root_trial;
    logic                      root_fits;

    logic                      r_out_valid;
    logic [sfp_pkg::VAL_W-1:0] r_out_data;

    logic                      div_busy;
    logic [sfp_pkg::VAL_W-1:0] div_quot;
    logic                      div_rem_zero;
    logic                      out_free;

    sfp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == sfp_pkg::OP_DIV),
        .i_dividend (r_v),
        .i_divisor  (r_f),
        .o_busy     (div_busy),
        .o_quot     (div_quot),
        .o_rem_zero (div_rem_zero)
    );

    assign mul_done   = r_mul_busy && (r_mb == '0);
    assign rem_sh     = {r_srem[sfp_pkg::RW-3:0], r_src[sfp_pkg::SRC_W-1 -: 2]};
    assign root_trial = {1'b0, r_root, 2'b01};
    assign root_fits  = rem_sh >= root_trial;
    assign out_free   = !r_out_valid || i_out_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy  <= 1'b0;
            r_scnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == sfp_pkg::OP_MUL_KF || i_cmd.op == sfp_pkg::OP_MUL_KV) begin
                r_mul_busy <= 1'b1;
            end else if (mul_done) begin
                r_mul_busy <= 1'b0;
            end
            if (i_cmd.op == sfp_pkg::OP_SQRT) begin
                r_scnt <= sfp_pkg::SQ_CW'(sfp_pkg::SQ_IT);
            end else if (r_scnt != '0) begin
                r_scnt <= r_scnt - 1'b1;
            end
            if (i_cmd.op == sfp_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (mul_done) begin
            r_keep <= r_macc;
        end else if (r_mul_busy) begin
            if (r_mb[0]) begin
                r_macc <= r_macc + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end

        if (r_scnt != '0) begin
            r_src  <= r_src << 2;
            r_srem <= root_fits ? rem_sh - root_trial : rem_sh;
            r_root <= {r_root[sfp_pkg::SQ_IT-2:0], root_fits};
        end

        unique case (i_cmd.op)
            sfp_pkg::OP_LOAD: begin
                r_v    <= i_in_data;
                r_keep <= sfp_pkg::VAL_W'(1);
                r_f    <= sfp_pkg::FW'(3);
                r_g    <= sfp_pkg::GW'(11);
                r_sq   <= sfp_pkg::CW'(9);
                r_cube <= sfp_pkg::CW'(27);
                r_odd  <= 1'b0;
            end
            sfp_pkg::OP_SHR2: begin
                r_v <= r_v >> 2;
            end
            sfp_pkg::OP_SHR1: begin
                r_v    <= r_v >> 1;
                r_keep <= sfp_pkg::VAL_W'(2);
            end
            sfp_pkg::OP_TAKE: begin
                r_v   <= div_quot;
                r_odd <= !r_odd;
            end
            sfp_pkg::OP_MUL_KF: begin
                r_macc <= '0;
                r_ma   <= r_keep;
                r_mb   <= sfp_pkg::VAL_W'(r_f);
            end
            sfp_pkg::OP_MUL_KV: begin
                r_macc <= '0;
                r_ma   <= r_keep;
                r_mb   <= r_v;
            end
            sfp_pkg::OP_CUBE_A: begin
                r_cube <= r_cube + (r_sq << 2);
            end
            sfp_pkg::OP_CUBE_B: begin
                r_cube <= r_cube + (r_sq << 1);
            end
            sfp_pkg::OP_CUBE_C: begin
                // (f+2)^3 = f^3 + 6f^2 + 4(3f+2), (f+2)^2 = f^2 + 4(f+1)
                r_cube <= r_cube + (sfp_pkg::CW'(r_g) << 2);
                r_sq   <= r_sq + (sfp_pkg::CW'(r_f + 1'b1) << 2);
                r_f    <= r_f + sfp_pkg::FW'(2);
                r_g    <= r_g + sfp_pkg::GW'(6);
                r_odd  <= 1'b0;
            end
            sfp_pkg::OP_SQRT: begin
                r_src  <= sfp_pkg::SRC_W'(r_v);
                r_srem <= '0;
                r_root <= '0;
            end
            sfp_pkg::OP_SET_ONE: begin
                r_v <= sfp_pkg::VAL_W'(1);
            end
            sfp_pkg::OP_EMIT: begin
                r_out_data <= r_keep;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.v_zero      = r_v == '0;
        o_sts.v_low2_zero = r_v[1:0] == 2'b00;
        o_sts.v_low_zero  = !r_v[0];
        o_sts.cube_le_v   = r_cube <= sfp_pkg::CW'(r_v);
        o_sts.div_busy    = div_busy;
        o_sts.rem_zero    = div_rem_zero;
        o_sts.odd         = r_odd;
        o_sts.mul_busy    = r_mul_busy;
        o_sts.sqrt_busy   = r_scnt != '0;
        o_sts.sqrt_exact  = r_srem == '0;
        o_sts.out_free    = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hw/rtl/sfp_ctrl.sv]
// Controller: sequences stripping, trial division, root test and output.
module sfp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sfp_pkg::t_sts  i_sts,
    output sfp_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STRIP,
        S_TEST,
        S_DIV_WAIT,
        S_REDIV,
        S_MULF_WAIT,
        S_ADV_A,
        S_ADV_B,
        S_ADV_C,
        S_SQRT_WAIT,
        S_MULV,
        S_MULV_WAIT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = sfp_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = sfp_pkg::OP_LOAD;
                    n_state  = S_STRIP;
                end
            end
            S_STRIP: begin
                priority if (i_sts.v_zero) begin
                    n_state = S_MULV;
                end else if (i_sts.v_low2_zero) begin
                    o_cmd.op = sfp_pkg::OP_SHR2;
                end else if (i_sts.v_low_zero) begin
                    o_cmd.op = sfp_pkg::OP_SHR1;
                    n_state  = S_TEST;
                end else begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_sts.cube_le_v) begin
                    o_cmd.op = sfp_pkg::OP_DIV;
                    n_state  = S_DIV_WAIT;
                end else begin
                    o_cmd.op = sfp_pkg::OP_SQRT;
                    n_state  = S_SQRT_WAIT;
                end
            end
            S_DIV_WAIT: begin
                priority if (i_sts.div_busy) begin
                    n_state = S_DIV_WAIT;
                end else if (i_sts.rem_zero) begin
                    o_cmd.op = sfp_pkg::OP_TAKE;
                    n_state  = S_REDIV;
                end else if (i_sts.odd) begin
                    o_cmd.op = sfp_pkg::OP_MUL_KF;
                    n_state  = S_MULF_WAIT;
                end else begin
                    n_state = S_ADV_A;
                end
            end
            S_REDIV: begin
                o_cmd.op = sfp_pkg::OP_DIV;
                n_state  = S_DIV_WAIT;
            end
            S_MULF_WAIT: begin
                if (!i_sts.mul_busy) begin
                    n_state = S_ADV_A;
                end
            end
            S_ADV_A: begin
                o_cmd.op = sfp_pkg::OP_CUBE_A;
                n_state  = S_ADV_B;
            end
            S_ADV_B: begin
                o_cmd.op = sfp_pkg::OP_CUBE_B;
                n_state  = S_ADV_C;
            end
            S_ADV_C: begin
                o_cmd.op = sfp_pkg::OP_CUBE_C;
                n_state  = S_TEST;
            end
            S_SQRT_WAIT: begin
                if (!i_sts.sqrt_busy) begin
                    if (i_sts.sqrt_exact) begin
                        o_cmd.op = sfp_pkg::OP_SET_ONE;
                    end
                    n_state = S_MULV;
                end
            end
            S_MULV: begin
                o_cmd.op = sfp_pkg::OP_MUL_KV;
                n_state  = S_MULV_WAIT;
            end
            S_MULV_WAIT: begin
                if (!i_sts.mul_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = sfp_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

endmodule

[hw/rtl/square_free_part.sv]
// Top level of the square-free part block: stream ports, controller and datapath.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-----------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_..tready | tdata[62:0] number_in
//  m_axis    | out       | o_m_axis_tvalid/i_..tready | tdata[62:0] reduced_out
//
//  One item is worked at a time. Stripping drops factors of 4 a pair of zero bits
//  at a time; each odd trial factor f with f^3 <= v costs a bit-serial division
//  plus one more per exact division, a shift-add multiply when f is kept, and the
//  steps ADV_A, ADV_B and ADV_C to advance f, f^2 and f^3. The divider sets the
//  pace. A root test of what is left (skipped for zero) and a final multiply end
//  the item. Reset is synchronous, active low; no clearing pass. The result waits
//  in an output register; a stalled output holds the final step and a new input is
//  taken once the result has been moved into that register.
`include "square_free_part_defines.svh"

module square_free_part (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [sfp_pkg::TDATA_W-1:0]   i_s_axis_tdata,   // [62:0] number_in
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [sfp_pkg::TDATA_W-1:0]   o_m_axis_tdata    // [62:0] reduced_out
);

    sfp_pkg::t_cmd             cmd;
    sfp_pkg::t_sts             sts;
    logic [sfp_pkg::VAL_W-1:0] out_data;
    logic                      in_xact;
    logic                      units_busy;

    // Sequence each item through the datapath
    sfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the value, trial factor and arithmetic units
    sfp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_s_axis_tdata[sfp_pkg::VAL_W-1:0]),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (out_data),
        .i_out_ready (i_m_axis_tready)
    );

    // Pad the result up to whole bytes
    assign o_m_axis_tdata = sfp_pkg::TDATA_W'(out_data);
    assign in_xact        = i_s_axis_tvalid && o_s_axis_tready;
    assign units_busy     = sts.div_busy || sts.mul_busy || sts.sqrt_busy;

    // No arithmetic unit may still run while a new transaction can be taken
    `SFP_ASSERT(a_idle_units, i_clk, i_rst_n, !o_s_axis_tready || !units_busy, "unit busy while ready")
    // An accepted transaction closes the input until its result is in the output register
    `SFP_ASSERT_NEXT(a_ready_drops, i_clk, i_rst_n, in_xact, !o_s_axis_tready, "ready held after accept")
    // The output register fills only on the emit step
    `SFP_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, cmd.op == sfp_pkg::OP_EMIT, o_m_axis_tvalid, "emit lost")
    // A new result never overwrites one still waiting
    `SFP_ASSERT(a_no_overwrite, i_clk, i_rst_n, cmd.op != sfp_pkg::OP_EMIT || !o_m_axis_tvalid || i_m_axis_tready, "result overwritten")

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the square-free part block: corner values, then random smooth numbers.
module tb;
    import sfp_pkg::*;

    typedef logic [VAL_W-1:0] t_num;

    localparam int          LIMIT_CYCLES = 8_000_000;
    localparam int          RANDOM_ITEMS = 77;
    localparam int          CALM_ITEMS   = 20;    // tail of the run with no idling at all
    localparam int          DRAIN_CYCLES = 200;   // room for a late stray result
    localparam int          CORNER_COUNT = 23;
    localparam logic [63:0] MAX_NUM      = 64'h7FFF_FFFF_FFFF_FFFF;

    // Odd primes used to build random values; keeping factors small bounds the
    // trial division of the block to a few dozen factors per transaction.
    localparam int SMALL_PRIMES [17] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                                         53, 59, 61};

    // Zero, tiny values, prime and two-prime cofactors, an exact square of a prime
    // above the cube-root bound, powers of two at the top, and all ones.
    localparam t_num CORNER_NUMBERS [CORNER_COUNT] = '{
        63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd8, 63'd9, 63'd12, 63'd18, 63'd25, 63'd27,
        63'd343, 63'd4753, 63'd10403, 63'd65537, 63'd1018081, 63'd2036162,
        63'd1018081 << 40, 63'h2000_0000_0000_0000, 63'h4000_0000_0000_0000,
        63'd4052555153018976267, 63'd7450580596923828125, 63'h7FFF_FFFF_FFFF_FFFF
    };

    // Expected square-free parts in arrival order, and the checks on each result.
    class kernel_scoreboard;
        t_num expected_q[$];
        int   numbers_in;
        int   results_seen;
        int   ones_seen;
        int   errors;

        function logic [63:0] floor_root(logic [63:0] m);
            logic [63:0] r;
            logic [63:0] t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= m) r = t;
            end
            return r;
        endfunction

        // Keep each prime with odd exponent once; drop the ones with even exponent.
        function t_num kernel_of(t_num n);
            logic [63:0] v;
            logic [63:0] kept;
            logic [63:0] f;
            logic [63:0] r;
            bit          flip;
            if (n == 0) return '0;
            v    = 64'(n);
            kept = 1;
            while (v[1:0] == 2'b00) v = v >> 2;
            if (!v[0]) begin
                kept = 2;
                v    = v >> 1;
            end
            // trial division up to the cube root of what is left
            for (f = 3; f <= (v / f) / f; f += 2) begin
                flip = 1'b0;
                while (v % f == 0) begin
                    v    = v / f;
                    flip = !flip;
                end
                if (flip) kept = kept * f;
            end
            // the leftover is 1, p, p*q or p*p
            r = floor_root(v);
            if (r * r == v) v = 1;
            return t_num'(kept * v);
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= 10) $display("ERROR: %s", msg);
        endfunction

        function void note_input(t_num n);
            expected_q.push_back(kernel_of(n));
            numbers_in++;
        endfunction

        function void check_result(t_num got);
            t_num want;
            results_seen++;
            if (got == 1) ones_seen++;
            if (expected_q.size() == 0) begin
                complain($sformatf("result %0d arrived with nothing pending", got));
            end else begin
                want = expected_q.pop_front();
                if (got !== want)
                    complain($sformatf("reduced_out expected %0d, got %0d", want, got));
            end
        endfunction
    endclass

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic [TDATA_W-1:0] i_s_axis_tdata  = '0;
    logic               i_m_axis_tready = 1'b0;
    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [TDATA_W-1:0] o_m_axis_tdata;

    kernel_scoreboard   ledger = new();
    bit                 calm   = 1'b0;
    int                 cycle_count = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    square_free_part DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),    // [62:0] number_in
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)     // [62:0] reduced_out
    );

    // Build a random value from a tail of at most 2^18 (sometimes the square of a
    // number above the cube-root bound), usually times powers of small odd primes
    // and then shifted up so the high bits get exercised.
    function automatic t_num pick_number();
        logic [63:0] v;
        logic [63:0] pe;
        int unsigned p;
        int unsigned s;
        s = $urandom_range(256, 511);
        case ($urandom_range(0, 3))
            0:       v = 64'(s) * 64'(s);
            1:       v = 64'($urandom_range(1, 1 << 18));
            default: v = 64'($urandom_range(0, 4095));
        endcase
        if ($urandom_range(0, 4) != 0) begin
            repeat ($urandom_range(1, 24)) begin
                p  = SMALL_PRIMES[$urandom_range(0, 16)];
                pe = 64'(p);
                repeat ($urandom_range(0, 2)) pe = pe * p;
                if (v != 0 && v <= MAX_NUM / pe) v = v * pe;
            end
            if ($urandom_range(0, 1) == 0) begin
                while (v != 0 && !v[VAL_W-1]) v = v << 1;
            end else begin
                repeat ($urandom_range(0, 62)) if (!v[VAL_W-1]) v = v << 1;
            end
        end
        return t_num'(v);
    endfunction

    // Offer one number, sometimes after an idle gap, and hold it until the block takes the transaction.
    task automatic send_number(input t_num n);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= {$urandom, $urandom};
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= TDATA_W'(n);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        ledger.note_input(n);
    endtask

    // Stall the result side in bursts, with open stretches between them.
    initial begin
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    // Check every result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            ledger.check_result(o_m_axis_tdata[VAL_W-1:0]);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, ledger.expected_q.size());
            $display("square_free_part: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (CORNER_NUMBERS[i]) send_number(CORNER_NUMBERS[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
            send_number(pick_number());
        end
        i_s_axis_tvalid <= 1'b0;

        // drain: every result in, then a quiet stretch to catch strays
        while (ledger.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("reduced %0d numbers (%0d corner values, the rest smooth random values)",
                 ledger.numbers_in, CORNER_COUNT);
        $display("checked %0d results, %0d of them 1; %0d errors in %0d cycles",
                 ledger.results_seen, ledger.ones_seen, ledger.errors, cycle_count);
        if (ledger.errors == 0 && ledger.expected_q.size() == 0)
            $display("square_free_part: match");
        else
            $display("square_free_part: mismatch");
        $finish;
    end

endmodule
